### rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// shared types and defaults for the time-ordered event queue
// ----------------------------------------------------------------------------
package teq_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int ID_WIDTH_DEFAULT   = 16;
   localparam int TIME_WIDTH_DEFAULT = 48;
   localparam int CNT_WIDTH_DEFAULT  = $clog2(DEPTH_DEFAULT + 1);

   typedef enum logic [1:0] {
      KIND_INSERT      = 2'd0,
      KIND_REMOVE_ID   = 2'd1,
      KIND_REMOVE_HEAD = 2'd2,
      KIND_GET_NEXT    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      kind_type kind;
      logic     prior;
      logic     exec;
      logic     full;
   } cmd_type;

   // flags handed from one cell to the next, head towards tail
   typedef struct packed {
      logic scan;     // an earlier cell has ended the scan
      logic hit;      // this cell is the get-next match
      logic any_hit;  // some cell so far is the get-next match
      logic ins;      // insert position at or before this cell
      logic sel;      // some cell so far drives the result data
   } link_type;

endpackage

### rtl/teq_if.sv
// ----------------------------------------------------------------------------
// teq_if
// request and response channels of the time-ordered event queue
// ----------------------------------------------------------------------------
interface teq_req_if #(
   parameter int ID_WIDTH   = 16,
   parameter int TIME_WIDTH = 48
);
   logic                  valid;
   logic                  ready;
   logic [1:0]            kind;
   logic [ID_WIDTH-1:0]   proc_id;
   logic [TIME_WIDTH-1:0] event_time;
   logic                  prior;

   modport source (output valid, kind, proc_id, event_time, prior, input ready);
   modport sink   (input valid, kind, proc_id, event_time, prior, output ready);
endinterface

interface teq_rsp_if #(
   parameter int ID_WIDTH   = 16,
   parameter int TIME_WIDTH = 48,
   parameter int CNT_WIDTH  = teq_pkg::CNT_WIDTH_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [ID_WIDTH-1:0]   out_id;
   logic [TIME_WIDTH-1:0] out_time;
   logic [1:0]            status;
   logic [CNT_WIDTH-1:0]  occupancy;

   modport source (output valid, found, out_id, out_time, status, occupancy,
                   input ready);
   modport sink   (input valid, found, out_id, out_time, status, occupancy,
                   output ready);
endinterface

### rtl/teq_cell.sv
// ----------------------------------------------------------------------------
// teq_cell
// one slot of the sorted queue: compares locally, shifts with its neighbours
// ----------------------------------------------------------------------------
module teq_cell #(
   parameter int ID_WIDTH   = 16,
   parameter int TIME_WIDTH = 48
) (
   input  logic                     clock,
   input  teq_pkg::cmd_type         cmd,
   input  logic [ID_WIDTH-1:0]      key_id,
   input  logic [TIME_WIDTH-1:0]    key_time,
   input  logic                     occ,
   input  teq_pkg::link_type        link_in,
   output teq_pkg::link_type        link_out,
   input  logic [ID_WIDTH-1:0]      left_id,
   input  logic [TIME_WIDTH-1:0]    left_time,
   input  logic [ID_WIDTH-1:0]      right_id,
   input  logic [TIME_WIDTH-1:0]    right_time,
   input  logic [ID_WIDTH-1:0]      pass_in_id,
   input  logic [TIME_WIDTH-1:0]    pass_in_time,
   output logic [ID_WIDTH-1:0]      pass_out_id,
   output logic [TIME_WIDTH-1:0]    pass_out_time,
   output logic [ID_WIDTH-1:0]      slot_id,
   output logic [TIME_WIDTH-1:0]    slot_time
);
   import teq_pkg::*;

   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [TIME_WIDTH-1:0] time_ff, time_in;
   logic                  match, later, ins_here, term, first, sel;

   always_comb begin
      match    = occ && (id_ff == key_id);
      later    = occ && (time_ff > key_time);
      ins_here = !occ || (cmd.prior ? (time_ff >= key_time) : later);

      case (cmd.kind)
         KIND_REMOVE_ID:   term = match;
         KIND_REMOVE_HEAD: term = occ;
         KIND_GET_NEXT:    term = match || later;
         default:          term = 1'b0;
      endcase
      first = term && !link_in.scan;

      case (cmd.kind) inside
         KIND_REMOVE_ID, KIND_REMOVE_HEAD: sel = first;
         KIND_GET_NEXT:                    sel = link_in.hit && occ;
         default:                          sel = 1'b0;
      endcase

      link_out.scan    = link_in.scan || term;
      link_out.hit     = first && match;
      link_out.any_hit = link_in.any_hit || (first && match);
      link_out.ins     = ins_here;
      link_out.sel     = link_in.sel || sel;

      pass_out_id   = pass_in_id   | (sel ? id_ff   : '0);
      pass_out_time = pass_in_time | (sel ? time_ff : '0);

      // shift towards the tail on insert, towards the head on removal
      id_in   = id_ff;
      time_in = time_ff;
      if (cmd.exec) begin
         case (cmd.kind) inside
            KIND_INSERT: begin
               if (!cmd.full) begin
                  if (link_in.ins) begin
                     id_in   = left_id;
                     time_in = left_time;
                  end else if (ins_here) begin
                     id_in   = key_id;
                     time_in = key_time;
                  end
               end
            end
            KIND_REMOVE_ID, KIND_REMOVE_HEAD: begin
               if (link_out.scan) begin
                  id_in   = right_id;
                  time_in = right_time;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      time_ff <= time_in;
   end

   assign slot_id   = id_ff;
   assign slot_time = time_ff;

endmodule

### rtl/time_ordered_event_queue.sv
// ----------------------------------------------------------------------------
// time_ordered_event_queue
// sorted event list kept in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one request: insert, remove by id, remove head or
//   get-next-after-id, with proc_id, event_time and the prior flag
//   rsp_chan returns exactly one response per request: found, out_id,
//   out_time, status and the occupancy after the operation
//   both channels transfer on a rising edge with valid and ready high
// latency and throughput
//   a request is registered at acceptance and executed once the response
//   register is free or being emptied, when every cell compares and shifts
//   at once; the response register is loaded at that same edge, so one
//   request per cycle is sustained while rsp_chan.ready stays high
//   the execute cycle holds the flag chain that runs through all DEPTH cells
//   (first-match scan and result gather), which sets the clock for large DEPTH
// reset
//   synchronous, active high; the queue empties, no response is pending
//   slot contents are not cleared, only slots below the count are ever read
// stalls
//   while a response waits, one more request is accepted and held; it
//   executes as soon as the waiting response is taken
// ----------------------------------------------------------------------------
module time_ordered_event_queue #(
   parameter int DEPTH      = teq_pkg::DEPTH_DEFAULT,
   parameter int ID_WIDTH   = teq_pkg::ID_WIDTH_DEFAULT,
   parameter int TIME_WIDTH = teq_pkg::TIME_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   teq_req_if.sink   req_chan,
   teq_rsp_if.source rsp_chan
);
   import teq_pkg::*;

   localparam int CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] FULL_COUNT = CNT_WIDTH'(DEPTH);

   // request register
   logic                  pend_ff, pend_in;
   logic [1:0]            kind_ff;
   logic [ID_WIDTH-1:0]   key_id_ff;
   logic [TIME_WIDTH-1:0] key_time_ff;
   logic                  prior_ff;

   // queue fill and response register
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  found_ff, found_in;
   logic [ID_WIDTH-1:0]   out_id_ff, out_id_in;
   logic [TIME_WIDTH-1:0] out_time_ff, out_time_in;
   status_type            status_ff, status_in;

   logic       exec, accept, full, empty;
   cmd_type    cmd;
   kind_type   kind;

   // cell chain
   link_type              link [DEPTH+1];
   logic [ID_WIDTH-1:0]   pass_id [DEPTH+1];
   logic [TIME_WIDTH-1:0] pass_time [DEPTH+1];
   logic [ID_WIDTH-1:0]   cell_id [DEPTH];
   logic [TIME_WIDTH-1:0] cell_time [DEPTH];

   // execute when the response register is free or being emptied
   assign exec   = pend_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !pend_ff || exec;

   assign kind  = kind_type'(kind_ff);
   assign full  = (count_ff == FULL_COUNT);
   assign empty = (count_ff == '0);

   assign cmd.kind  = kind;
   assign cmd.prior = prior_ff;
   assign cmd.exec  = exec;
   assign cmd.full  = full;

   assign link[0]      = '0;
   assign pass_id[0]   = '0;
   assign pass_time[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_WIDTH-1:0] IDX = CNT_WIDTH'(i);
      logic [ID_WIDTH-1:0]   lid, rid;
      logic [TIME_WIDTH-1:0] ltime, rtime;

      // head takes the new entry from the key, tail keeps its own on removal
      if (i == 0) begin : g_head
         assign lid   = key_id_ff;
         assign ltime = key_time_ff;
      end else begin : g_body
         assign lid   = cell_id[i-1];
         assign ltime = cell_time[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign rid   = cell_id[i];
         assign rtime = cell_time[i];
      end else begin : g_inner
         assign rid   = cell_id[i+1];
         assign rtime = cell_time[i+1];
      end

      teq_cell #(
         .ID_WIDTH   (ID_WIDTH),
         .TIME_WIDTH (TIME_WIDTH)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .key_id        (key_id_ff),
         .key_time      (key_time_ff),
         .occ           (IDX < count_ff),
         .link_in       (link[i]),
         .link_out      (link[i+1]),
         .left_id       (lid),
         .left_time     (ltime),
         .right_id      (rid),
         .right_time    (rtime),
         .pass_in_id    (pass_id[i]),
         .pass_in_time  (pass_time[i]),
         .pass_out_id   (pass_id[i+1]),
         .pass_out_time (pass_time[i+1]),
         .slot_id       (cell_id[i]),
         .slot_time     (cell_time[i])
      );
   end

   // response and fill count for the request in execution
   always_comb begin
      pend_in      = accept || (pend_ff && !exec);
      rsp_valid_in = exec || (rsp_valid_ff && !rsp_chan.ready);
      found_in     = found_ff;
      out_id_in    = out_id_ff;
      out_time_in  = out_time_ff;
      status_in    = status_ff;
      count_in     = count_ff;

      if (exec) begin
         found_in    = 1'b0;
         out_id_in   = '0;
         out_time_in = '0;
         status_in   = STATUS_DONE;
         unique case (kind) inside
            KIND_INSERT: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            KIND_REMOVE_ID, KIND_REMOVE_HEAD: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else if (link[DEPTH].sel) begin
                  found_in    = 1'b1;
                  out_id_in   = pass_id[DEPTH];
                  out_time_in = pass_time[DEPTH];
                  count_in    = count_ff - 1'b1;
               end
            end
            KIND_GET_NEXT: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else if (link[DEPTH].any_hit) begin
                  // successor of the match, absent when the match is the tail
                  found_in    = link[DEPTH].sel;
                  out_id_in   = pass_id[DEPTH];
                  out_time_in = pass_time[DEPTH];
               end else begin
                  // id not reached before a later time: fall back to the head
                  found_in    = 1'b1;
                  out_id_in   = cell_id[0];
                  out_time_in = cell_time[0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_chan.kind;
         key_id_ff   <= req_chan.proc_id;
         key_time_ff <= req_chan.event_time;
         prior_ff    <= req_chan.prior;
      end
      found_ff    <= found_in;
      out_id_ff   <= out_id_in;
      out_time_ff <= out_time_in;
      status_ff   <= status_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.found     = found_ff;
   assign rsp_chan.out_id    = out_id_ff;
   assign rsp_chan.out_time  = out_time_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.occupancy = count_ff;

   // fill count never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

   // an accepted insert into a non-full queue adds exactly one entry
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      exec && (kind == KIND_INSERT) && !full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the queue");

   // a dropped insert only happens on a full queue
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_FULL) |-> count_ff == FULL_COUNT)
      else $error("full status on a queue with room");

   // an empty report never carries an entry
   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_EMPTY) |-> !found_ff && (count_ff == '0))
      else $error("empty status with an entry or a non-empty queue");

   // a waiting response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(out_id_ff)
         && $stable(count_ff))
      else $error("response changed while stalled");

endmodule
